/* hdl/calendar_clock_with_countdown_unit_macros.svh */
// Assertion helpers shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_COUNTDOWN_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_WITH_COUNTDOWN_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar clock package
// Word types, operation codes, counter limits and reset values for the calendar clock.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SET_SEC   = 3'd1;
    localparam logic [2:0] OP_SET_MIN   = 3'd2;
    localparam logic [2:0] OP_SET_HOUR  = 3'd3;
    localparam logic [2:0] OP_SET_DAY   = 3'd4;
    localparam logic [2:0] OP_SET_MONTH = 3'd5;
    localparam logic [2:0] OP_SET_YEAR  = 3'd6;
    localparam logic [2:0] OP_START_CD  = 3'd7;

    localparam logic [7:0] SEC_LIMIT   = 8'd60;
    localparam logic [7:0] MIN_LIMIT   = 8'd60;
    localparam logic [7:0] HOUR_LIMIT  = 8'd24;
    localparam logic [7:0] DAY_LIMIT   = 8'd32;
    localparam logic [7:0] MONTH_LIMIT = 8'd13;
    localparam logic [7:0] CD_MAX_MIN  = 8'd99;
    localparam logic [5:0] CD_SEC_TOP  = 6'd59;

    localparam logic [7:0] RST_SEC   = 8'd50;
    localparam logic [7:0] RST_MIN   = 8'd59;
    localparam logic [7:0] RST_HOUR  = 8'd23;
    localparam logic [7:0] RST_DAY   = 8'd18;
    localparam logic [7:0] RST_MONTH = 8'd9;
    localparam logic [7:0] RST_YEAR  = 8'd19;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] second_now;
        logic [7:0] minute_now;
        logic [7:0] hour_now;
        logic [7:0] day_now;
        logic [7:0] month_now;
        logic [7:0] year_now;
        logic [6:0] countdown_minutes;
        logic [5:0] countdown_seconds;
    } t_out_word;

endpackage

`default_nettype wire

/* hdl/calendar_clock_with_countdown_unit.sv */
// ----------------------------------------------------------------------------
// Calendar clock with countdown
// Usage: each input word is a one-second tick, a write of one clock field or
// the start of a minute:second countdown; each one yields one output word
// holding the whole clock and countdown state after that word.
// Channels: input i_in_valid/o_in_stall/i_in_word, output
// o_out_valid/i_out_stall/o_out_word. A word moves when valid is high and
// stall is low.
// Path: an accepted input word waits in the input register, then the state
// update writes the result register, which drives the output.
// Throughput: one word per cycle while the output is not stalled; the single
// update stage is the only work.
// Reset: synchronous, active low; the clock loads 23:59:50 on day 18, month
// 9, year 19, the countdown reads 0:00 and both pipeline registers empty.
// Stall: while the result register holds a word that is stalled, the update
// stage waits and the input register keeps its word; the input side then
// stalls only if that register is full, so one more word is still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_with_countdown_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ccc_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ccc_pkg::t_out_word     o_out_word
);
    import ccc_pkg::*;

    `include "calendar_clock_with_countdown_unit_macros.svh"

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic [7:0] r_sec, r_min, r_hour, r_day, r_month, r_year;
    logic [6:0] r_cd_min;
    logic [5:0] r_cd_sec;

    logic [7:0] n_sec, n_min, n_hour, n_day, n_month, n_year;
    logic [6:0] n_cd_min;
    logic [5:0] n_cd_sec;

    logic [7:0] sec_inc, min_inc, hour_inc, day_inc, month_inc;
    logic       out_block;
    logic       in_take;
    logic       fire;

    assign out_block  = r_out_valid & i_out_stall;
    assign fire       = r_in_valid & ~out_block;
    assign o_in_stall = r_in_valid & out_block;
    assign in_take    = i_in_valid & ~o_in_stall;

    assign sec_inc   = r_sec + 8'd1;
    assign min_inc   = r_min + 8'd1;
    assign hour_inc  = r_hour + 8'd1;
    assign day_inc   = r_day + 8'd1;
    assign month_inc = r_month + 8'd1;

    always_comb begin
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_cd_min = r_cd_min;
        n_cd_sec = r_cd_sec;
        case (r_in_word.operation)
            OP_TICK: begin
                if (r_cd_sec != 6'd0) begin
                    n_cd_sec = r_cd_sec - 6'd1;
                end else if (r_cd_min != 7'd0) begin
                    n_cd_sec = CD_SEC_TOP;
                    n_cd_min = r_cd_min - 7'd1;
                end
                // Each counter up to the month rolls over only when its increment lands exactly
                // on the limit, so out-of-range values count up through 255.
                n_sec = sec_inc;
                if (sec_inc == SEC_LIMIT) begin
                    n_sec = 8'd0;
                    n_min = min_inc;
                    if (min_inc == MIN_LIMIT) begin
                        n_min  = 8'd0;
                        n_hour = hour_inc;
                        if (hour_inc == HOUR_LIMIT) begin
                            n_hour = 8'd0;
                            n_day  = day_inc;
                            if (day_inc == DAY_LIMIT) begin
                                n_day   = 8'd1;
                                n_month = month_inc;
                                if (month_inc == MONTH_LIMIT) begin
                                    n_month = 8'd1;
                                    n_year  = r_year + 8'd1;
                                end
                            end
                        end
                    end
                end
            end
            OP_SET_SEC:   n_sec   = r_in_word.value;
            OP_SET_MIN:   n_min   = r_in_word.value;
            OP_SET_HOUR:  n_hour  = r_in_word.value;
            OP_SET_DAY:   n_day   = r_in_word.value;
            OP_SET_MONTH: n_month = r_in_word.value;
            OP_SET_YEAR:  n_year  = r_in_word.value;
            OP_START_CD: begin
                n_cd_min = (r_in_word.value > CD_MAX_MIN) ? CD_MAX_MIN[6:0]
                                                          : r_in_word.value[6:0];
                n_cd_sec = 6'd0;
            end
            default: begin
                n_cd_sec = r_cd_sec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sec       <= RST_SEC;
            r_min       <= RST_MIN;
            r_hour      <= RST_HOUR;
            r_day       <= RST_DAY;
            r_month     <= RST_MONTH;
            r_year      <= RST_YEAR;
            r_cd_min    <= 7'd0;
            r_cd_sec    <= 6'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_sec       <= n_sec;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
                r_cd_min    <= n_cd_min;
                r_cd_sec    <= n_cd_sec;
            end else if (!out_block) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_out_word <= '{second_now:        n_sec,
                            minute_now:        n_min,
                            hour_now:          n_hour,
                            day_now:           n_day,
                            month_now:         n_month,
                            year_now:          n_year,
                            countdown_minutes: n_cd_min,
                            countdown_seconds: n_cd_sec};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `CCC_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, r_out_valid,
                     "update stage fired but no result word followed")
    `CCC_ASSERT_NEXT(a_block_holds_state, i_clk, i_rst_n, out_block,
                     $stable(r_sec) && $stable(r_cd_sec) && $stable(r_year),
                     "clock state moved while the result word was stalled")
    `CCC_ASSERT_IMPL(a_cd_in_range, i_clk, i_rst_n, r_out_valid,
                     (r_cd_sec <= CD_SEC_TOP) && (r_cd_min <= CD_MAX_MIN[6:0]),
                     "countdown left its range")
    `CCC_ASSERT_IMPL(a_result_matches_state, i_clk, i_rst_n, r_out_valid,
                     (o_out_word.second_now == r_sec) &&
                     (o_out_word.countdown_seconds == r_cd_sec),
                     "result word differs from the clock state")

endmodule

`default_nettype wire
